// ===== rtl/nearest_neighbor_scale_address_gen_top_macros.svh =====
// Assertion macros for the nearest-neighbour scaling address generator.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef NEAREST_NEIGHBOR_SCALE_ADDRESS_GEN_TOP_MACROS_SVH
`define NEAREST_NEIGHBOR_SCALE_ADDRESS_GEN_TOP_MACROS_SVH

`define NNSAG_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`define NNSAG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define NNSAG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/nnsag_pkg.sv =====
// Shared types and constants for the nearest-neighbour scaling address generator.
// Used by the configuration, controller, datapath and top-level modules.
`timescale 1ns / 1ps
`default_nettype none

package nnsag_pkg;

  localparam int RATIO_W  = 27;
  localparam int DIM_W    = 11;
  localparam int ORIGIN_W = 10;
  localparam int PITCH_W  = 13;
  localparam int BPP_W    = 3;
  localparam int OFF_W    = 22;
  localparam int COORD_W  = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 27;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_X_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BPP      = 3'd7;

  localparam logic [RATIO_W-1:0]  RST_X_STEP   = 27'd65537;
  localparam logic [RATIO_W-1:0]  RST_Y_STEP   = 27'd65537;
  localparam logic [DIM_W-1:0]    RST_WIDTH    = 11'd320;
  localparam logic [DIM_W-1:0]    RST_HEIGHT   = 11'd240;
  localparam logic [ORIGIN_W-1:0] RST_ORIGIN_X = 10'd0;
  localparam logic [ORIGIN_W-1:0] RST_ORIGIN_Y = 10'd0;
  localparam logic [PITCH_W-1:0]  RST_PITCH    = 13'd640;
  localparam logic [BPP_W-1:0]    RST_BPP      = 3'd2;

  typedef struct packed {
    logic [RATIO_W-1:0]  x_step_ratio;
    logic [RATIO_W-1:0]  y_step_ratio;
    logic [DIM_W-1:0]    dest_width;
    logic [DIM_W-1:0]    dest_height;
    logic [ORIGIN_W-1:0] dest_origin_x;
    logic [ORIGIN_W-1:0] dest_origin_y;
    logic [PITCH_W-1:0]  source_pitch;
    logic [BPP_W-1:0]    source_bytes_per_pixel;
  } cfg_regs_t;

  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } stage_state_t;

  typedef struct packed {
    logic stage_load;
    logic out_load;
  } dp_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/nnsag_cfg.sv =====
// Configuration register file, written through a plain index/data port.
// Depends on nnsag_pkg for register indexes, widths and reset values.
`timescale 1ns / 1ps
`default_nettype none

module nnsag_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [nnsag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [nnsag_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output nnsag_pkg::cfg_regs_t                    regs
);
  import nnsag_pkg::*;

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_X_STEP:   regs_nxt.x_step_ratio = cfg_wdata[RATIO_W-1:0];
        REG_Y_STEP:   regs_nxt.y_step_ratio = cfg_wdata[RATIO_W-1:0];
        REG_WIDTH:    regs_nxt.dest_width = cfg_wdata[DIM_W-1:0];
        REG_HEIGHT:   regs_nxt.dest_height = cfg_wdata[DIM_W-1:0];
        REG_ORIGIN_X: regs_nxt.dest_origin_x = cfg_wdata[ORIGIN_W-1:0];
        REG_ORIGIN_Y: regs_nxt.dest_origin_y = cfg_wdata[ORIGIN_W-1:0];
        REG_PITCH:    regs_nxt.source_pitch = cfg_wdata[PITCH_W-1:0];
        REG_BPP:      regs_nxt.source_bytes_per_pixel = cfg_wdata[BPP_W-1:0];
        default:      regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.x_step_ratio           <= RST_X_STEP;
      regs_r.y_step_ratio           <= RST_Y_STEP;
      regs_r.dest_width             <= RST_WIDTH;
      regs_r.dest_height            <= RST_HEIGHT;
      regs_r.dest_origin_x          <= RST_ORIGIN_X;
      regs_r.dest_origin_y          <= RST_ORIGIN_Y;
      regs_r.source_pitch           <= RST_PITCH;
      regs_r.source_bytes_per_pixel <= RST_BPP;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

`default_nettype wire

// ===== rtl/nnsag_ctrl.sv =====
// Controller: tracks the position stage and the output register and issues load commands.
// Depends on nnsag_pkg for the stage state type and the command struct.
`timescale 1ns / 1ps
`default_nettype none

module nnsag_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output nnsag_pkg::dp_cmd_t cmd,
  output logic               stage_full
);
  import nnsag_pkg::*;

  stage_state_t state_r;
  stage_state_t state_nxt;
  logic         out_valid_r;
  logic         out_valid_nxt;
  logic         out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EMPTY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    out_free       = !out_valid_r || out_tready;
    cmd.out_load   = 1'b0;
    in_tready      = 1'b0;
    state_nxt      = state_r;
    case (state_r)
      ST_EMPTY: begin
        in_tready = 1'b1;
      end
      ST_FULL: begin
        cmd.out_load = out_free;
        in_tready    = out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
    cmd.stage_load = in_tvalid && in_tready;
    if (cmd.stage_load) begin
      state_nxt = ST_FULL;
    end else if (cmd.out_load) begin
      state_nxt = ST_EMPTY;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign stage_full = (state_r == ST_FULL);

endmodule

`default_nettype wire

// ===== rtl/nnsag_dp.sv =====
// Datapath: position counters, step accumulators, position stage and offset multiply.
// Depends on nnsag_pkg for the configuration struct, widths and the command struct.
`timescale 1ns / 1ps
`default_nettype none

module nnsag_dp #(
  parameter int MAX_DIMENSION = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire nnsag_pkg::cfg_regs_t            regs,
  input  wire nnsag_pkg::dp_cmd_t              cmd,
  input  wire logic                            restart,
  output logic [nnsag_pkg::OFF_W-1:0]          source_offset,
  output logic [nnsag_pkg::COORD_W-1:0]        dest_x,
  output logic [nnsag_pkg::COORD_W-1:0]        dest_y,
  output logic                                 row_end,
  output logic                                 frame_end
);
  import nnsag_pkg::*;

  localparam int IDX_W = $clog2(MAX_DIMENSION);
  localparam int ACC_W = IDX_W + RATIO_W;
  localparam int CMP_W = ((IDX_W > DIM_W) ? IDX_W : DIM_W) + 1;
  localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIMENSION);

  logic [IDX_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [ACC_W-1:0] cacc_r, cacc_nxt, racc_r, racc_nxt;

  logic [IDX_W-1:0] eff_col, eff_row;
  logic [ACC_W-1:0] eff_cacc, eff_racc, sx_full, sy_full;
  logic [CMP_W-1:0] width_c, height_c, width_m1, height_m1;
  logic             last_col, last_row;

  logic [OFF_W-1:0]   st_sx_r, st_sy_r;
  logic [COORD_W-1:0] st_dx_r, st_dy_r;
  logic               st_row_end_r, st_frame_end_r;

  logic [OFF_W+PITCH_W-1:0] prod_y;
  logic [OFF_W+BPP_W-1:0]   prod_x;

  logic [OFF_W-1:0]   out_off_r;
  logic [COORD_W-1:0] out_dx_r, out_dy_r;
  logic               out_row_end_r, out_frame_end_r;

  always_comb begin
    if (regs.dest_width == '0) begin
      width_c = CMP_W'(1);
    end else if (CMP_W'(regs.dest_width) > MAX_DIM_C) begin
      width_c = MAX_DIM_C;
    end else begin
      width_c = CMP_W'(regs.dest_width);
    end
    if (regs.dest_height == '0) begin
      height_c = CMP_W'(1);
    end else if (CMP_W'(regs.dest_height) > MAX_DIM_C) begin
      height_c = MAX_DIM_C;
    end else begin
      height_c = CMP_W'(regs.dest_height);
    end
    width_m1  = width_c - CMP_W'(1);
    height_m1 = height_c - CMP_W'(1);

    eff_col  = restart ? '0 : col_r;
    eff_row  = restart ? '0 : row_r;
    eff_cacc = restart ? '0 : cacc_r;
    eff_racc = restart ? '0 : racc_r;

    last_col = CMP_W'(eff_col) >= width_m1;
    last_row = CMP_W'(eff_row) >= height_m1;

    sx_full = eff_cacc >> FRACTION_BITS;
    sy_full = eff_racc >> FRACTION_BITS;

    col_nxt  = col_r;
    row_nxt  = row_r;
    cacc_nxt = cacc_r;
    racc_nxt = racc_r;
    if (cmd.stage_load) begin
      if (!last_col) begin
        col_nxt  = eff_col + IDX_W'(1);
        cacc_nxt = eff_cacc + ACC_W'(regs.x_step_ratio);
        row_nxt  = eff_row;
        racc_nxt = eff_racc;
      end else if (!last_row) begin
        col_nxt  = '0;
        cacc_nxt = '0;
        row_nxt  = eff_row + IDX_W'(1);
        racc_nxt = eff_racc + ACC_W'(regs.y_step_ratio);
      end else begin
        col_nxt  = '0;
        cacc_nxt = '0;
        row_nxt  = '0;
        racc_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      cacc_r <= '0;
      racc_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      cacc_r <= cacc_nxt;
      racc_r <= racc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stage_load) begin
      st_sx_r        <= sx_full[OFF_W-1:0];
      st_sy_r        <= sy_full[OFF_W-1:0];
      st_dx_r        <= COORD_W'(regs.dest_origin_x) + COORD_W'(eff_col);
      st_dy_r        <= COORD_W'(regs.dest_origin_y) + COORD_W'(eff_row);
      st_row_end_r   <= last_col;
      st_frame_end_r <= last_col && last_row;
    end
  end

  assign prod_y = st_sy_r * regs.source_pitch;
  assign prod_x = st_sx_r * regs.source_bytes_per_pixel;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_off_r       <= prod_y[OFF_W-1:0] + prod_x[OFF_W-1:0];
      out_dx_r        <= st_dx_r;
      out_dy_r        <= st_dy_r;
      out_row_end_r   <= st_row_end_r;
      out_frame_end_r <= st_frame_end_r;
    end
  end

  assign source_offset = out_off_r;
  assign dest_x        = out_dx_r;
  assign dest_y        = out_dy_r;
  assign row_end       = out_row_end_r;
  assign frame_end     = out_frame_end_r;

endmodule

`default_nettype wire

// ===== rtl/nearest_neighbor_scale_address_gen_top.sv =====
// Nearest-neighbour scaling address generator, top level.
// Each input item yields one result item: source byte offset, screen position and end marks.
// The input item carries a restart flag in bit 0 of in_tdata; restart returns the walk to
// destination pixel (0,0) before that item's result is formed.
// Results appear on the out_ stream after the accepted item has passed the position stage,
// where the step accumulators have been advanced, and then the output register, which the
// offset multiplier feeds; the item moves on into the output register only once that
// register is free, so a stalled receiver holds it in the position stage.
// Throughput is one item per cycle while the receiver keeps out_tready high; the rate is set
// by the accumulator update, a single add per item.
// When the receiver stalls, the result waits in the output register and one more item may
// be taken into the position stage; after that in_tready stays low until the output drains.
// Configuration registers are written through cfg_we, cfg_index and cfg_wdata, and should
// only be changed while no item is in flight.
// Reset (rst_n low, synchronous) loads the register defaults, returns the walk to (0,0)
// and empties both stages; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module nearest_neighbor_scale_address_gen_top #(
  parameter int MAX_DIMENSION = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // Bit 0: restart; bits 7:1 are zero fill.
  input  wire logic [nnsag_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // Bits 21:0 source_offset, 32:22 dest_x, 43:33 dest_y, 47:44 zero fill.
  output logic [nnsag_pkg::OUT_TDATA_W-1:0]         out_tdata,
  output logic                                      out_tlast,
  // Bit 0: frame_end.
  output logic                                      out_tuser,
  input  wire logic                                 cfg_we,
  input  wire logic [nnsag_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [nnsag_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import nnsag_pkg::*;

  cfg_regs_t          regs;
  dp_cmd_t            cmd;
  logic               stage_full;
  logic [OFF_W-1:0]   source_offset;
  logic [COORD_W-1:0] dest_x;
  logic [COORD_W-1:0] dest_y;

  nnsag_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  nnsag_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stage_full (stage_full)
  );

  nnsag_dp #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .regs          (regs),
    .cmd           (cmd),
    .restart       (in_tdata[0]),
    .source_offset (source_offset),
    .dest_x        (dest_x),
    .dest_y        (dest_y),
    .row_end       (out_tlast),
    .frame_end     (out_tuser)
  );

  assign out_tdata = {(OUT_TDATA_W - OFF_W - 2 * COORD_W)'(0), dest_y, dest_x, source_offset};

`include "nearest_neighbor_scale_address_gen_top_macros.svh"

  `NNSAG_ASSERT_IMPL(a_stall_blocks_input, stage_full && out_tvalid && !out_tready, !in_tready, "input taken while both stages are held")
  `NNSAG_ASSERT_NEXT(a_accept_fills_stage, in_tvalid && in_tready, stage_full || out_tvalid, "accepted item lost before output")
  `NNSAG_ASSERT_IMPL(a_frame_end_is_row_end, out_tvalid && out_tuser, out_tlast, "frame end without row end")
  `NNSAG_ASSERT_ALWAYS(a_empty_stage_ready, stage_full || in_tready, "input not ready with an empty stage")

endmodule

`default_nettype wire

// ===== tb/nearest_neighbor_scale_address_gen_top_tb.sv =====
// Self-checking testbench for the nearest-neighbour scaling address generator.
// Predicts source offset, screen position and end marks for every item; needs nnsag_pkg
// and the design RTL files with the assertion macro header.
`timescale 1ns / 1ps

module nearest_neighbor_scale_address_gen_top_tb;
  import nnsag_pkg::*;

  localparam int MAX_DIM   = 1024;
  localparam int FRAC_BITS = 16;
  localparam int RANDOM_ITEMS = 1300;

  typedef struct packed {
    logic [OFF_W-1:0]   source_offset;
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    logic               row_end;
    logic               frame_end;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;
  logic out_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  cfg_regs_t shadow;
  logic [9:0]  col_idx;
  logic [9:0]  row_idx;
  logic [36:0] col_acc;
  logic [36:0] row_acc;

  bit     pending_restarts[$];
  pixel_t expected_pixels[$];
  int     mismatch_count = 0;
  int     items_queued = 0;
  int     send_gap = 0;
  int     recv_stall = 0;
  bit     sender_idles = 1'b1;
  bit     receiver_idles = 1'b1;
  logic   in_fired = 1'b0;

  nearest_neighbor_scale_address_gen_top #(
    .MAX_DIMENSION(MAX_DIM),
    .FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int clamp_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic void home_walk();
    col_idx = '0;
    row_idx = '0;
    col_acc = '0;
    row_acc = '0;
  endfunction

  function automatic pixel_t scan_pixel(logic restart);
    int cols;
    int rows;
    logic [63:0] sx;
    logic [63:0] sy;
    logic [63:0] offset;
    logic last_col;
    logic last_row;
    pixel_t p;
    cols = clamp_dim(shadow.dest_width);
    rows = clamp_dim(shadow.dest_height);
    if (restart) home_walk();
    sx = 64'(col_acc >> FRAC_BITS);
    sy = 64'(row_acc >> FRAC_BITS);
    offset = sy * 64'(shadow.source_pitch) + sx * 64'(shadow.source_bytes_per_pixel);
    last_col = int'(col_idx) >= cols - 1;
    last_row = int'(row_idx) >= rows - 1;
    p.source_offset = offset[OFF_W-1:0];
    p.dest_x = COORD_W'(shadow.dest_origin_x) + COORD_W'(col_idx);
    p.dest_y = COORD_W'(shadow.dest_origin_y) + COORD_W'(row_idx);
    p.row_end = last_col;
    p.frame_end = last_col && last_row;
    if (!last_col) begin
      col_idx++;
      col_acc += 37'(shadow.x_step_ratio);
    end else if (!last_row) begin
      col_idx = '0;
      col_acc = '0;
      row_idx++;
      row_acc += 37'(shadow.y_step_ratio);
    end else begin
      home_walk();
    end
    return p;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Sender: presents queued items, then waits its drawn gap before the next one.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fired) begin
      if (send_gap != 0) begin
        in_tvalid <= 1'b0;
        send_gap--;
      end else if (pending_restarts.size() != 0) begin
        in_tdata <= IN_TDATA_W'(pending_restarts.pop_front());
        in_tvalid <= 1'b1;
        send_gap = sender_idles ? $urandom_range(0, 9) : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (recv_stall != 0) begin
      out_tready <= 1'b0;
      recv_stall--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch
    pixel_t got;
    pixel_t want;
    if (rst_n) begin
      in_fired <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) expected_pixels.push_back(scan_pixel(in_tdata[0]));
      if (out_tvalid && out_tready) begin
        got.source_offset = out_tdata[OFF_W-1:0];
        got.dest_x = out_tdata[OFF_W +: COORD_W];
        got.dest_y = out_tdata[OFF_W+COORD_W +: COORD_W];
        got.row_end = out_tlast;
        got.frame_end = out_tuser;
        if (expected_pixels.size() == 0) begin
          $error("result item arrived with no item outstanding");
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("source_offset", 32'(want.source_offset), 32'(got.source_offset));
          check_field("dest_x", 32'(want.dest_x), 32'(got.dest_x));
          check_field("dest_y", 32'(want.dest_y), 32'(got.dest_y));
          check_field("row_end", 32'(want.row_end), 32'(got.row_end));
          check_field("frame_end", 32'(want.frame_end), 32'(got.frame_end));
        end
        recv_stall = receiver_idles ? $urandom_range(0, 9) : 0;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_X_STEP:   shadow.x_step_ratio = val[RATIO_W-1:0];
      REG_Y_STEP:   shadow.y_step_ratio = val[RATIO_W-1:0];
      REG_WIDTH:    shadow.dest_width = val[DIM_W-1:0];
      REG_HEIGHT:   shadow.dest_height = val[DIM_W-1:0];
      REG_ORIGIN_X: shadow.dest_origin_x = val[ORIGIN_W-1:0];
      REG_ORIGIN_Y: shadow.dest_origin_y = val[ORIGIN_W-1:0];
      REG_PITCH:    shadow.source_pitch = val[PITCH_W-1:0];
      REG_BPP:      shadow.source_bytes_per_pixel = val[BPP_W-1:0];
      default:      ;
    endcase
  endtask

  task automatic close_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(int unsigned xs, int unsigned ys, int unsigned w, int unsigned h,
                           int unsigned ox, int unsigned oy, int unsigned pitch,
                           int unsigned bpp);
    write_reg(REG_X_STEP, CFG_DATA_W'(xs));
    write_reg(REG_Y_STEP, CFG_DATA_W'(ys));
    write_reg(REG_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_ORIGIN_X, CFG_DATA_W'(ox));
    write_reg(REG_ORIGIN_Y, CFG_DATA_W'(oy));
    write_reg(REG_PITCH, CFG_DATA_W'(pitch));
    write_reg(REG_BPP, CFG_DATA_W'(bpp));
    close_writes();
  endtask

  task automatic shuffle_registers();
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] val;
    for (int r = 0; r <= int'(REG_BPP); r++) begin
      idx = r[CFG_IDX_W-1:0];
      val = '0;
      case (idx)
        REG_X_STEP, REG_Y_STEP:
          case ($urandom_range(0, 5))
            0: val = '0;
            1: val = {RATIO_W{1'b1}};
            2: val = CFG_DATA_W'($urandom);
            default: val = CFG_DATA_W'((($urandom_range(1, 2048) << FRAC_BITS)
                                        / $urandom_range(1, 64)) + 1);
          endcase
        REG_WIDTH, REG_HEIGHT:
          case ($urandom_range(0, 9))
            0: val = '0;
            1: val = CFG_DATA_W'($urandom_range(1024, 2047));
            2: val = CFG_DATA_W'($urandom_range(0, 2047));
            default: val = CFG_DATA_W'($urandom_range(1, 12));
          endcase
        REG_ORIGIN_X, REG_ORIGIN_Y:
          case ($urandom_range(0, 3))
            0: val = '0;
            1: val = CFG_DATA_W'(1023);
            default: val = CFG_DATA_W'($urandom_range(0, 1023));
          endcase
        REG_PITCH:
          case ($urandom_range(0, 5))
            0: val = '0;
            1: val = {PITCH_W{1'b1}};
            2: val = CFG_DATA_W'($urandom_range(0, 8191));
            default: val = CFG_DATA_W'($urandom_range(1, 4096));
          endcase
        REG_BPP: val = CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                                : $urandom_range(1, 4));
        default: val = '0;
      endcase
      if ($urandom_range(0, 2) != 0) write_reg(idx, val);
    end
    close_writes();
  endtask

  task automatic send_bits(logic [15:0] restarts, int count);
    @(posedge clk);
    for (int k = 0; k < count; k++) pending_restarts.push_back(restarts[k]);
    items_queued += count;
  endtask

  task automatic send_random(int count);
    @(posedge clk);
    pending_restarts.push_back(1'($urandom_range(0, 1)));
    for (int k = 1; k < count; k++) pending_restarts.push_back($urandom_range(0, 15) == 0);
    items_queued += count;
  endtask

  // Waits until the sender is empty and every predicted result has been taken.
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_restarts.size() != 0 || in_tvalid || expected_pixels.size() != 0);
  endtask

  task automatic pick_idling();
    sender_idles = $urandom_range(0, 3) != 0;
    receiver_idles = $urandom_range(0, 3) != 0;
  endtask

  initial begin
    shadow = '{x_step_ratio: RST_X_STEP, y_step_ratio: RST_Y_STEP,
               dest_width: RST_WIDTH, dest_height: RST_HEIGHT,
               dest_origin_x: RST_ORIGIN_X, dest_origin_y: RST_ORIGIN_Y,
               source_pitch: RST_PITCH, source_bytes_per_pixel: RST_BPP};
    home_walk();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings.
    send_bits(16'h0001, 3);
    wait_drained();

    // All registers at their extremes: zero width, oversized height, wrapping offsets.
    pick_idling();
    write_all((1 << RATIO_W) - 1, (1 << RATIO_W) - 1, 0, 2047, 1023, 1023, 8191, 7);
    send_bits(16'h0001, 5);
    wait_drained();

    // Small frame with zero step, pitch and pixel size: wraps at frame end, restarts mid-row.
    pick_idling();
    write_all(0, 0, 3, 2, 0, 0, 0, 0);
    send_bits(16'h0081, 8);
    wait_drained();

    // Widen in mid-row; the accumulators carry on from their old sums.
    write_all('h20000, 'h20000, 1024, 1024, 5, 7, 4096, 4);
    send_bits(16'h0000, 3);
    wait_drained();

    // Shrink below the current column so the walk wraps at once.
    write_reg(REG_WIDTH, CFG_DATA_W'(2));
    write_reg(REG_HEIGHT, CFG_DATA_W'(1));
    close_writes();
    send_bits(16'h0000, 3);
    wait_drained();

    while (items_queued < RANDOM_ITEMS + 22) begin
      pick_idling();
      shuffle_registers();
      send_random($urandom_range(10, 60));
      wait_drained();
    end

    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/nnsag_pkg.sv
rtl/nnsag_cfg.sv
rtl/nnsag_ctrl.sv
rtl/nnsag_dp.sv
rtl/nearest_neighbor_scale_address_gen_top.sv
tb/nearest_neighbor_scale_address_gen_top_tb.sv
